### hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define SN_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define SN_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/sha1nid_pkg.sv
`timescale 1ns / 1ps

package sha1nid_pkg;

    localparam int DATA_W   = 8;
    localparam int NID_W    = 32;
    localparam int CNT_W    = 7;
    localparam int RND_W    = 7;
    localparam int N_WORDS  = 16;

    localparam logic [RND_W-1:0] LAST_ROUND = 7'd79;
    localparam logic [RND_W-1:0] RND_K1     = 7'd20;
    localparam logic [RND_W-1:0] RND_K2     = 7'd40;
    localparam logic [RND_W-1:0] RND_K3     = 7'd60;

    localparam logic [31:0] H0 = 32'h67452301;
    localparam logic [31:0] H1 = 32'hEFCDAB89;
    localparam logic [31:0] H2 = 32'h98BADCFE;
    localparam logic [31:0] H3 = 32'h10325476;
    localparam logic [31:0] H4 = 32'hC3D2E1F0;

    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    localparam logic [DATA_W-1:0] PAD_BYTE = 8'h80;
    localparam logic [CNT_W-1:0]  MAX_LEN  = 7'd63;

endpackage

### hdl/sha1nid_if.sv
`timescale 1ns / 1ps

interface sha1nid_in_if import sha1nid_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data_byte;
    logic              byte_valid;
    logic              last_byte;

    modport source (output valid, data_byte, byte_valid, last_byte, input ready);
    modport sink   (input valid, data_byte, byte_valid, last_byte, output ready);
endinterface

interface sha1nid_out_if import sha1nid_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [NID_W-1:0] nid;
    logic             too_long;

    modport source (output valid, nid, too_long, input ready);
    modport sink   (input valid, nid, too_long, output ready);
endinterface

### hdl/sha1_single_block_nid.sv
`timescale 1ns / 1ps

// Takes a message one byte per beat (one beat per cycle while collecting) and
// returns the byte-swapped first SHA-1 digest word of a single padded block.
// After the beat that carries last_byte the input is not ready until the finish
// state is left: the pad state builds the padded block in the schedule shift
// register, the one shared round unit runs the 80 rounds one per cycle, and the
// finish state adds the first initial word into the output register. A message
// of more than 63 bytes goes straight to the finish state, with too_long set and
// nid zero. The finish state waits while an earlier result is still held there.
module sha1_single_block_nid import sha1nid_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sha1nid_in_if.sink    i_in,
    sha1nid_out_if.source o_out
);

    typedef enum logic [1:0] {S_IDLE, S_PAD, S_ROUND, S_FIN} t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic [RND_W-1:0] r_round;
    logic [31:0]      r_w [N_WORDS];
    logic [31:0]      w_pad [N_WORDS];
    logic [7:0]       w_pad_byte;
    logic [31:0]      r_a, r_b, r_c, r_d, r_e;
    logic [31:0]      w_f, w_k, w_tmp, w_sum;
    logic             r_too_long;
    logic             r_out_valid;
    logic [NID_W-1:0] r_nid;
    logic             r_out_too_long;
    logic             w_in_acc;
    logic             w_slot_free;

    assign i_in.ready     = (r_state == S_IDLE);
    assign w_in_acc       = i_in.valid && i_in.ready;
    assign w_slot_free    = !r_out_valid || o_out.ready;
    assign o_out.valid    = r_out_valid;
    assign o_out.nid      = r_nid;
    assign o_out.too_long = r_out_too_long;

    // count holds at 64 once the message is too long
    assign n_cnt = (i_in.byte_valid && !r_cnt[CNT_W-1]) ? r_cnt + 1'b1 : r_cnt;

    // padded block: message, 0x80, zeros, bit length in bytes 62 and 63
    always_comb begin
        w_pad_byte = '0;
        for (int k = 0; k < N_WORDS; k++) begin
            w_pad[k] = '0;
            for (int j = 0; j < 4; j++) begin
                if (6'(4 * k + j) < r_cnt[5:0]) begin
                    w_pad_byte = r_w[k][8 * (3 - j) +: 8];
                end else if (6'(4 * k + j) == r_cnt[5:0]) begin
                    w_pad_byte = PAD_BYTE;
                end else begin
                    w_pad_byte = '0;
                end
                if (4 * k + j == 62) begin
                    w_pad_byte = {7'b0, r_cnt[5]};
                end
                if (4 * k + j == 63) begin
                    w_pad_byte = {r_cnt[4:0], 3'b000};
                end
                w_pad[k][8 * (3 - j) +: 8] = w_pad_byte;
            end
        end
    end

    // shared round unit
    always_comb begin
        if (r_round < RND_K1) begin
            w_f = (r_b & (r_c ^ r_d)) ^ r_d;
            w_k = K0;
        end else if (r_round < RND_K2) begin
            w_f = r_b ^ r_c ^ r_d;
            w_k = K1;
        end else if (r_round < RND_K3) begin
            w_f = ((r_b | r_c) & r_d) | (r_b & r_c);
            w_k = K2;
        end else begin
            w_f = r_b ^ r_c ^ r_d;
            w_k = K3;
        end
        w_tmp = {r_a[26:0], r_a[31:27]} + w_f + r_e + w_k + r_w[0];
        w_sum = r_a + H0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_round     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // the finish state decides the output slot itself
            if (o_out.ready && r_state != S_FIN) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        if (i_in.byte_valid && !r_cnt[CNT_W-1]) begin
                            r_w[r_cnt[5:2]][{~r_cnt[1:0], 3'b000} +: 8] <= i_in.data_byte;
                        end
                        if (i_in.last_byte) begin
                            r_too_long <= (n_cnt > MAX_LEN);
                            if (n_cnt > MAX_LEN) begin
                                r_cnt   <= '0;
                                r_state <= S_FIN;
                            end else begin
                                r_cnt   <= n_cnt;
                                r_state <= S_PAD;
                            end
                        end else begin
                            r_cnt <= n_cnt;
                        end
                    end
                end
                S_PAD: begin
                    r_w     <= w_pad;
                    r_a     <= H0;
                    r_b     <= H1;
                    r_c     <= H2;
                    r_d     <= H3;
                    r_e     <= H4;
                    r_cnt   <= '0;
                    r_round <= '0;
                    r_state <= S_ROUND;
                end
                S_ROUND: begin
                    // schedule window holds w[t..t+15]
                    for (int k = 0; k < N_WORDS - 1; k++) begin
                        r_w[k] <= r_w[k + 1];
                    end
                    r_w[N_WORDS-1] <= {r_w[13][30:0] ^ r_w[8][30:0]
                                           ^ r_w[2][30:0] ^ r_w[0][30:0],
                                       r_w[13][31] ^ r_w[8][31] ^ r_w[2][31] ^ r_w[0][31]};
                    r_e     <= r_d;
                    r_d     <= r_c;
                    r_c     <= {r_b[1:0], r_b[31:2]};
                    r_b     <= r_a;
                    r_a     <= w_tmp;
                    r_round <= r_round + 1'b1;
                    if (r_round == LAST_ROUND) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (w_slot_free) begin
                        r_out_valid    <= 1'b1;
                        r_out_too_long <= r_too_long;
                        r_nid          <= r_too_long ? '0 :
                                          {w_sum[7:0], w_sum[15:8], w_sum[23:16], w_sum[31:24]};
                        r_round        <= '0;
                        r_state        <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### hdl/sha1nid_chk.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sha1nid_chk import sha1nid_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic             i_last_byte,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [NID_W-1:0] i_nid,
    input logic             i_too_long
);

    `SN_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_nid) && $stable(i_too_long), "stalled result beat changed")
    `SN_ASSERT_NXT(a_busy_after_last, i_clk, i_rst_n, i_in_valid && i_in_ready && i_last_byte, !i_in_ready, "input ready right after the closing beat")
    `SN_ASSERT_IMP(a_long_zero, i_clk, i_rst_n, i_out_valid && i_too_long, i_nid == '0, "rejected message gave nonzero nid")
    `SN_ASSERT_IMP(a_result_while_busy, i_clk, i_rst_n, $rose(i_out_valid), !$past(i_in_ready), "result appeared while collecting bytes")

endmodule

bind sha1_single_block_nid sha1nid_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_last_byte (i_in.last_byte),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_nid       (o_out.nid),
    .i_too_long  (o_out.too_long)
);

### tb/sha1nid_checker.sv
`timescale 1ns / 1ps

module sha1nid_checker import sha1nid_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    sha1nid_in_if  in_mon,
    sha1nid_out_if out_mon,
    output int    o_err_count,
    output int    o_pending
);

    typedef struct packed {
        logic [NID_W-1:0] nid;
        logic             too_long;
    } nid_result_t;

    logic [DATA_W-1:0] msg_buf [0:63];
    int                msg_len;
    logic              msg_over;
    nid_result_t       nid_expect_q [$];

    initial o_err_count = 0;

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        o_err_count++;
    endtask

    // single padded block, 80 rounds, first word plus its initial value, byte-swapped
    function automatic logic [NID_W-1:0] sha1_nid_of(input int len);
        logic [7:0]  blk [0:63];
        logic [31:0] w [0:15];
        logic [31:0] a, b, c, d, e, f, k, wt, mix, tmp, sum;
        logic [15:0] bit_len;
        int          i, t;
        for (i = 0; i < 64; i++) begin
            blk[i] = (i < len) ? msg_buf[i] : 8'h00;
        end
        blk[len & 63] = PAD_BYTE;
        // bit length lands on bytes 62 and 63 even when that clobbers pad or data
        bit_len = 16'(len * 8);
        blk[62] = bit_len[15:8];
        blk[63] = bit_len[7:0];
        for (i = 0; i < 16; i++) begin
            w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
        end
        a = H0;
        b = H1;
        c = H2;
        d = H3;
        e = H4;
        for (t = 0; t < 80; t++) begin
            if (t < 16) begin
                wt = w[t];
            end else begin
                mix = w[(t + 13) & 15] ^ w[(t + 8) & 15] ^ w[(t + 2) & 15] ^ w[t & 15];
                wt = {mix[30:0], mix[31]};
                w[t & 15] = wt;
            end
            if (t < 20) begin
                f = (b & (c ^ d)) ^ d;
                k = K0;
            end else if (t < 40) begin
                f = b ^ c ^ d;
                k = K1;
            end else if (t < 60) begin
                f = ((b | c) & d) | (b & c);
                k = K2;
            end else begin
                f = b ^ c ^ d;
                k = K3;
            end
            tmp = {a[26:0], a[31:27]} + f + e + k + wt;
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = tmp;
        end
        sum = a + H0;
        return {sum[7:0], sum[15:8], sum[23:16], sum[31:24]};
    endfunction

    task automatic absorb_beat(input logic [DATA_W-1:0] data, input logic bv, input logic lb);
        nid_result_t res;
        if (bv) begin
            if (msg_len < 64) begin
                msg_buf[msg_len] = data;
                msg_len++;
            end
            if (msg_len > 63) msg_over = 1'b1;
        end
        if (lb) begin
            if (msg_over || msg_len > 63) begin
                res.nid      = '0;
                res.too_long = 1'b1;
            end else begin
                res.nid      = sha1_nid_of(msg_len);
                res.too_long = 1'b0;
            end
            nid_expect_q.push_back(res);
            msg_len  = 0;
            msg_over = 1'b0;
        end
    endtask

    task automatic check_result(input logic [NID_W-1:0] nid, input logic too_long);
        nid_result_t exp_res;
        if (nid_expect_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result nid=%h too_long=%b", nid, too_long));
        end else begin
            exp_res = nid_expect_q.pop_front();
            if (nid !== exp_res.nid)
                report_mismatch($sformatf("nid %h, want %h", nid, exp_res.nid));
            if (too_long !== exp_res.too_long)
                report_mismatch($sformatf("too_long %b, want %b", too_long, exp_res.too_long));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            msg_len  = 0;
            msg_over = 1'b0;
            nid_expect_q.delete();
        end else begin
            if (in_mon.valid && in_mon.ready)
                absorb_beat(in_mon.data_byte, in_mon.byte_valid, in_mon.last_byte);
            if (out_mon.valid && out_mon.ready)
                check_result(out_mon.nid, out_mon.too_long);
        end
        o_pending <= nid_expect_q.size();
    end

endmodule

### tb/tb_sha1_single_block_nid.sv
`timescale 1ns / 1ps

module tb_sha1_single_block_nid;
    import sha1nid_pkg::*;

    localparam int ITEM_TARGET = 1600;
    localparam int CYCLE_LIMIT = 500000;
    localparam int DRAIN_LIMIT = 20000;

    logic i_clk;
    logic i_rst_n;

    sha1nid_in_if  in_if ();
    sha1nid_out_if out_if ();

    int err_count;
    int pending;
    int items_sent;
    int burst_left;
    int cycle_cnt;
    int rx_cycle;
    int hold_left;

    sha1_single_block_nid u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    sha1nid_checker u_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .in_mon      (in_if),
        .out_mon     (out_if),
        .o_err_count (err_count),
        .o_pending   (pending)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("[%0t] timeout after %0d cycles", $time, cycle_cnt);
            $display("tb_sha1_single_block_nid failed");
            $finish;
        end
    end

    // receiver: own stall pattern that steps through four modes, plus two long hold-offs
    always @(posedge i_clk) begin
        rx_cycle++;
        if (hold_left > 0) begin
            hold_left--;
            out_if.ready <= 1'b0;
        end else if (rx_cycle == 1500 || rx_cycle == 9000) begin
            hold_left = 700;
            out_if.ready <= 1'b0;
        end else begin
            case (rx_cycle[9:8])
                2'd0: out_if.ready <= 1'b1;
                2'd1: out_if.ready <= 1'($urandom_range(0, 1));
                2'd2: out_if.ready <= ($urandom_range(0, 3) == 0);
                default: out_if.ready <= (rx_cycle[2:0] != 3'd0);
            endcase
        end
    end

    task automatic drive_beat(input logic [DATA_W-1:0] data, input logic bv, input logic lb);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 60);
        end
        in_if.valid      <= 1'b1;
        in_if.data_byte  <= data;
        in_if.byte_valid <= bv;
        in_if.last_byte  <= lb;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        burst_left--;
        if (bv || lb) items_sent++;
    endtask

    // random content; ends on the last byte or on a separate end beat
    task automatic send_message(input int len);
        logic end_on_byte;
        int   i;
        end_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
        for (i = 0; i < len; i++) begin
            if ($urandom_range(0, 9) == 0)
                drive_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            drive_beat(8'($urandom_range(0, 255)), 1'b1, end_on_byte && (i == len - 1));
        end
        if (!end_on_byte)
            drive_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) return $urandom_range(0, 15);
        if (r < 60) return $urandom_range(16, 55);
        if (r < 85) return $urandom_range(56, 63);
        return $urandom_range(64, 90);
    endfunction

    initial begin
        int waited;
        int n;
        in_if.valid      <= 1'b0;
        in_if.data_byte  <= '0;
        in_if.byte_valid <= 1'b0;
        in_if.last_byte  <= 1'b0;
        i_rst_n          <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // idle beat, the empty message, three one-byte messages, then "abc"
        drive_beat(8'h5A, 1'b0, 1'b0);
        drive_beat(8'hA5, 1'b0, 1'b1);
        drive_beat(8'h00, 1'b1, 1'b1);
        drive_beat(8'hFF, 1'b1, 1'b1);
        drive_beat(8'h80, 1'b1, 1'b1);
        drive_beat(8'h61, 1'b1, 1'b0);
        drive_beat(8'h62, 1'b1, 1'b0);
        drive_beat(8'h63, 1'b1, 1'b1);
        // byte then end beat carrying no byte; idle beat then another empty message
        drive_beat(8'hC3, 1'b1, 1'b0);
        drive_beat(8'hFF, 1'b0, 1'b1);
        drive_beat(8'h00, 1'b0, 1'b0);
        drive_beat(8'h00, 1'b0, 1'b1);

        // lengths around the padding overlap and the overflow edge
        for (n = 54; n <= 66; n++) send_message(n);
        send_message(0);
        send_message(1);

        while (items_sent < ITEM_TARGET) send_message(pick_length());

        in_if.valid <= 1'b0;
        waited = 0;
        @(posedge i_clk);
        while (pending != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (100) @(posedge i_clk);
        if (pending != 0)
            $display("[%0t] %0d results never arrived", $time, pending);
        if (err_count == 0 && pending == 0)
            $display("tb_sha1_single_block_nid passed");
        else
            $display("tb_sha1_single_block_nid failed");
        $finish;
    end

endmodule

### files.f
+incdir+hdl
hdl/sha1nid_pkg.sv
hdl/sha1nid_if.sv
hdl/sha1_single_block_nid.sv
hdl/sha1nid_chk.sv
tb/sha1nid_checker.sv
tb/tb_sha1_single_block_nid.sv
